// ===== hdl/lwsd_pkg.sv =====
// lwsd_pkg: shared constants, register indexes and controller/datapath types
// for the local window standard deviation filter
// no dependencies
package lwsd_pkg;

    // limits of the block
    localparam int MAX_WIDTH       = 4096;
    localparam int MAX_HEIGHT      = 4096;
    localparam int MAX_HALF_WINDOW = 15;

    // field widths
    localparam int PIX_W      = 8;
    localparam int DIM_W      = 13;
    localparam int HALF_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // derived widths
    localparam int W_W      = $clog2(MAX_WIDTH + 1);
    localparam int H_W      = $clog2(MAX_HEIGHT + 1);
    localparam int M_W      = $clog2(MAX_HALF_WINDOW + 1);
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int SLOTS    = 2 * MAX_HALF_WINDOW + 1;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int DEPTH    = SLOTS * MAX_WIDTH;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int PIX_MAX  = 2 ** PIX_W - 1;
    localparam int AREA_MAX = SLOTS * SLOTS;
    localparam int CNT_W    = $clog2(AREA_MAX + 1);
    localparam int SUMB_W   = $clog2(AREA_MAX * PIX_MAX + 1);
    localparam int SUMA_W   = $clog2(AREA_MAX * PIX_MAX * PIX_MAX + 1);
    localparam int PROD_W   = CNT_W + SUMA_W;
    localparam int ROOT_W   = (PROD_W + 1) / 2;
    localparam int SQ_W     = 2 * ROOT_W;
    localparam int STEP_W   = $clog2(ROOT_W);
    localparam int TIDX_W   = $clog2(MAX_WIDTH * MAX_HEIGHT
                                     + MAX_HALF_WINDOW * MAX_WIDTH + MAX_HALF_WINDOW + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_NONZERO = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_MASK_ZERO     = CFG_IDX_W'(4);

    // register reset values
    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH   = DIM_W'(640);
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT  = DIM_W'(480);
    localparam logic [HALF_W-1:0] RST_HALF_WINDOW   = HALF_W'(10);
    localparam logic              RST_COUNT_NONZERO = 1'b1;
    localparam logic              RST_MASK_ZERO     = 1'b0;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic advance;
        logic zero;
        logic scan_start;
        logic scan_step;
        logic mul_a;
        logic mul_b;
        logic sub;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic emit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic in_valid;
        logic drain_skip;
        logic has_result;
        logic border;
        logic scan_last;
        logic zero_res;
        logic sqrt_last;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

// ===== hdl/lwsd_if.sv =====
// lwsd_if: handshake channel interfaces for pixel input, result output and
// register writes; depends on lwsd_pkg
interface lwsd_in_if import lwsd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             drain;
    modport source(output valid, pixel, drain, input ready);
    modport sink(input valid, pixel, drain, output ready);
endinterface

interface lwsd_out_if import lwsd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] deviation;
    logic             frame_last;
    modport source(output valid, deviation, frame_last, input ready);
    modport sink(input valid, deviation, frame_last, output ready);
endinterface

interface lwsd_cfg_if import lwsd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/lwsd_ctrl.sv =====
// lwsd_ctrl: sequencer for one beat at a time through classify, window scan,
// multiply, square root, divide and result hand-off; depends on lwsd_pkg
module lwsd_ctrl import lwsd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASS,
        S_SCAN,
        S_FLUSH,
        S_MUL_A,
        S_MUL_B,
        S_SUB,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = 1'b1;
                if (i_st.in_valid) begin
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                if (i_st.drain_skip) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                    if (!i_st.has_result) begin
                        n_state = S_IDLE;
                    end else if (i_st.border) begin
                        o_cmd.zero = 1'b1;
                        n_state    = S_EMIT;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_st.scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_MUL_A;
            end
            S_MUL_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = i_st.zero_res ? S_EMIT : S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_st.sqrt_last) begin
                    n_state = S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_st.div_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // checks
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_st.out_free)
        else $error("result loaded while output register still full");

    a_accept_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_st.in_valid) |=> (r_state == S_CLASS))
        else $error("accepted beat not classified");

    a_sqrt_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && i_st.sqrt_last) |=> (r_state == S_DIV_INIT))
        else $error("square root did not hand over to divider");

endmodule

// ===== hdl/lwsd_datapath.sv =====
// lwsd_datapath: config registers, row store, frame counters, window scan
// accumulators, multipliers, square root and divider; depends on lwsd_pkg, lwsd_if
module lwsd_datapath import lwsd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_status          o_st,
    lwsd_in_if.sink          i_in,
    lwsd_cfg_if.sink         i_cfg,
    lwsd_out_if.source       o_out
);

    localparam int BRD_W = ((W_W > H_W) ? W_W : H_W) + 1;

    // configuration registers
    logic [DIM_W-1:0]  r_cfg_width;
    logic [DIM_W-1:0]  r_cfg_height;
    logic [HALF_W-1:0] r_cfg_half;
    logic              r_cfg_nonzero;
    logic              r_cfg_mask;
    logic              cfg_wr;
    logic              cfg_hit;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid & i_cfg.ready;

    always_comb begin
        unique case (i_cfg.index)
            REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_HALF_WINDOW,
            REG_COUNT_NONZERO, REG_MASK_ZERO: cfg_hit = 1'b1;
            default:                          cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width   <= RST_IMAGE_WIDTH;
            r_cfg_height  <= RST_IMAGE_HEIGHT;
            r_cfg_half    <= RST_HALF_WINDOW;
            r_cfg_nonzero <= RST_COUNT_NONZERO;
            r_cfg_mask    <= RST_MASK_ZERO;
        end else if (cfg_wr) begin
            unique case (i_cfg.index)
                REG_IMAGE_WIDTH:   r_cfg_width   <= i_cfg.data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  r_cfg_height  <= i_cfg.data[DIM_W-1:0];
                REG_HALF_WINDOW:   r_cfg_half    <= i_cfg.data[HALF_W-1:0];
                REG_COUNT_NONZERO: r_cfg_nonzero <= i_cfg.data[0];
                REG_MASK_ZERO:     r_cfg_mask    <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // effective geometry, saturated, and derived figures
    logic [W_W-1:0]    eff_w;
    logic [H_W-1:0]    eff_h;
    logic [M_W-1:0]    eff_m;
    logic [M_W:0]      eff_side;
    logic [W_W-1:0]    r_w;
    logic [H_W-1:0]    r_h;
    logic [M_W-1:0]    r_m;
    logic [SLOT_W-1:0] r_m2;
    logic [TIDX_W-1:0] r_total;
    logic [TIDX_W-1:0] r_delay;
    logic [CNT_W-1:0]  r_area;

    always_comb begin
        if (r_cfg_width == '0) begin
            eff_w = W_W'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            eff_w = W_W'(MAX_WIDTH);
        end else begin
            eff_w = W_W'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            eff_h = H_W'(1);
        end else if (32'(r_cfg_height) > MAX_HEIGHT) begin
            eff_h = H_W'(MAX_HEIGHT);
        end else begin
            eff_h = H_W'(r_cfg_height);
        end
        if (32'(r_cfg_half) > MAX_HALF_WINDOW) begin
            eff_m = M_W'(MAX_HALF_WINDOW);
        end else begin
            eff_m = M_W'(r_cfg_half);
        end
        eff_side = {eff_m, 1'b1};
    end

    always_ff @(posedge i_clk) begin
        r_w     <= eff_w;
        r_h     <= eff_h;
        r_m     <= eff_m;
        r_m2    <= SLOT_W'({eff_m, 1'b0});
        r_total <= TIDX_W'(eff_w) * TIDX_W'(eff_h);
        r_delay <= TIDX_W'(eff_m) * TIDX_W'(eff_w) + TIDX_W'(eff_m);
        r_area  <= CNT_W'(eff_side) * CNT_W'(eff_side);
    end

    // input beat capture
    logic [PIX_W-1:0] r_pixel;
    logic             r_drain;

    assign i_in.ready = i_cmd.accept;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_in.valid) begin
            r_pixel <= i_in.pixel;
            r_drain <= i_in.drain;
        end
    end

    // frame position counters
    logic [TIDX_W-1:0] r_t;
    logic [COL_W-1:0]  r_icol;
    logic [SLOT_W-1:0] r_islot;
    logic [TIDX_W-1:0] r_pidx;
    logic [ROW_W-1:0]  r_prow;
    logic [COL_W-1:0]  r_pcol;
    logic [SLOT_W-1:0] r_oslot;
    logic              pix_phase;
    logic              frame_end;
    logic              border;
    logic [COL_W-1:0]  last_col;

    assign pix_phase = r_t < r_total;
    assign frame_end = r_pidx == (r_total - TIDX_W'(1));
    assign last_col  = COL_W'(r_w - W_W'(1));
    assign border    = (BRD_W'(r_prow) < BRD_W'(r_m))
                    || (BRD_W'(r_pcol) < BRD_W'(r_m))
                    || ((BRD_W'(r_prow) + BRD_W'(r_m)) >= BRD_W'(r_h))
                    || ((BRD_W'(r_pcol) + BRD_W'(r_m)) >= BRD_W'(r_w));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (cfg_wr && cfg_hit)) begin
            r_t     <= '0;
            r_icol  <= '0;
            r_islot <= '0;
            r_pidx  <= '0;
            r_prow  <= '0;
            r_pcol  <= '0;
            r_oslot <= '0;
        end else if (i_cmd.emit && frame_end) begin
            r_t     <= '0;
            r_icol  <= '0;
            r_islot <= '0;
            r_pidx  <= '0;
            r_prow  <= '0;
            r_pcol  <= '0;
            r_oslot <= '0;
        end else begin
            // writer side: one beat consumed
            if (i_cmd.advance) begin
                r_t <= r_t + TIDX_W'(1);
                if (pix_phase) begin
                    if (r_icol == last_col) begin
                        r_icol  <= '0;
                        r_islot <= (r_islot == r_m2) ? '0 : r_islot + SLOT_W'(1);
                    end else begin
                        r_icol <= r_icol + COL_W'(1);
                    end
                end
            end
            // reader side: one result delivered
            if (i_cmd.emit) begin
                r_pidx <= r_pidx + TIDX_W'(1);
                if (r_pcol == last_col) begin
                    r_pcol  <= '0;
                    r_prow  <= r_prow + ROW_W'(1);
                    r_oslot <= (r_oslot == r_m2) ? '0 : r_oslot + SLOT_W'(1);
                end else begin
                    r_pcol <= r_pcol + COL_W'(1);
                end
            end
        end
    end

    // window scan counters
    logic [SLOT_W-1:0] r_sslot;
    logic [SLOT_W-1:0] r_sj;
    logic              scan_last;
    logic              scan_centre;
    logic [COL_W-1:0]  rd_col;

    assign scan_last   = (r_sslot == r_m2) && (r_sj == r_m2);
    assign scan_centre = (r_sslot == r_oslot) && (r_sj == SLOT_W'(r_m));
    assign rd_col      = r_pcol - COL_W'(r_m) + COL_W'(r_sj);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sslot <= '0;
            r_sj    <= '0;
        end else if (i_cmd.scan_start) begin
            r_sslot <= '0;
            r_sj    <= '0;
        end else if (i_cmd.scan_step) begin
            if (r_sj == r_m2) begin
                r_sj    <= '0;
                r_sslot <= r_sslot + SLOT_W'(1);
            end else begin
                r_sj <= r_sj + SLOT_W'(1);
            end
        end
    end

    // row store: slot-major, one row of MAX_WIDTH per slot
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
                                                    input logic [COL_W-1:0]  col);
        return ADDR_W'(slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
    endfunction

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rd_data;
    logic             r_rd_vld;
    logic             r_rd_ctr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.advance && pix_phase) begin
            r_mem[slot_addr(r_islot, r_icol)] <= r_pixel;
        end
        if (i_cmd.scan_step) begin
            r_rd_data <= r_mem[slot_addr(r_sslot, rd_col)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_rd_ctr <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_step;
            r_rd_ctr <= i_cmd.scan_step & scan_centre;
        end
    end

    // window accumulators
    logic [SUMB_W-1:0]  r_sum_b;
    logic [SUMA_W-1:0]  r_sum_a;
    logic [CNT_W-1:0]   r_cnt;
    logic [PIX_W-1:0]   r_centre;
    logic [2*PIX_W-1:0] pix_sq;

    assign pix_sq = (2*PIX_W)'(r_rd_data) * (2*PIX_W)'(r_rd_data);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_sum_b <= '0;
            r_sum_a <= '0;
            r_cnt   <= '0;
        end else if (r_rd_vld) begin
            r_sum_b <= r_sum_b + SUMB_W'(r_rd_data);
            r_sum_a <= r_sum_a + SUMA_W'(pix_sq);
            r_cnt   <= r_cnt + CNT_W'(|r_rd_data);
        end
        if (r_rd_ctr) begin
            r_centre <= r_rd_data;
        end
    end

    // divisor choice and products
    logic [CNT_W-1:0]    n_sel;
    logic                zero_res;
    logic [PROD_W-1:0]   prod_a;
    logic [2*SUMB_W-1:0] prod_b;
    logic [CNT_W-1:0]    r_n;
    logic [PROD_W-1:0]   r_prod_a;
    logic [2*SUMB_W-1:0] r_prod_b;

    assign n_sel    = r_cfg_nonzero ? r_cnt : r_area;
    assign zero_res = (r_cfg_mask && (r_centre == '0)) || (n_sel == '0);
    assign prod_a   = PROD_W'(n_sel) * PROD_W'(r_sum_a);
    assign prod_b   = (2*SUMB_W)'(r_sum_b) * (2*SUMB_W)'(r_sum_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_a) begin
            r_n      <= n_sel;
            r_prod_a <= prod_a;
        end
        if (i_cmd.mul_b) begin
            r_prod_b <= prod_b;
        end
    end

    // bit-pair square root
    logic [SQ_W-1:0] r_v;
    logic [SQ_W-1:0] r_root;
    logic [SQ_W-1:0] r_bit;
    logic [SQ_W-1:0] sq_trial;
    logic [SQ_W-1:0] pa_ext;
    logic [SQ_W-1:0] pb_ext;

    assign sq_trial = r_root + r_bit;
    assign pa_ext   = SQ_W'(r_prod_a);
    assign pb_ext   = SQ_W'(r_prod_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sub) begin
            r_v    <= (pa_ext >= pb_ext) ? pa_ext - pb_ext : '0;
            r_root <= '0;
            r_bit  <= SQ_W'(1) << (SQ_W - 2);
        end else if (i_cmd.sqrt_step) begin
            if (r_v >= sq_trial) begin
                r_v    <= r_v - sq_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // restoring divider, root by n
    logic [ROOT_W-1:0] r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_dcnt;
    logic [CNT_W:0]    rem_sh;

    assign rem_sh = {r_rem, r_q[ROOT_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.zero || (i_cmd.mul_a && zero_res)) begin
            r_q <= '0;
        end else if (i_cmd.div_init) begin
            r_q    <= r_root[ROOT_W-1:0];
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            if (rem_sh >= {1'b0, r_n}) begin
                r_rem <= CNT_W'(rem_sh - {1'b0, r_n});
                r_q   <= {r_q[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[CNT_W-1:0];
                r_q   <= {r_q[ROOT_W-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt + STEP_W'(1);
        end
    end

    // output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_dev;
    logic             r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_dev  <= (|r_q[ROOT_W-1:PIX_W]) ? '1 : r_q[PIX_W-1:0];
            r_out_last <= frame_end;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.deviation  = r_out_dev;
    assign o_out.frame_last = r_out_last;

    // status to controller
    always_comb begin
        o_st.in_valid   = i_in.valid;
        o_st.drain_skip = pix_phase & r_drain;
        o_st.has_result = r_t >= r_delay;
        o_st.border     = border;
        o_st.scan_last  = scan_last;
        o_st.zero_res   = zero_res;
        o_st.sqrt_last  = r_bit[0];
        o_st.div_last   = r_dcnt == STEP_W'(ROOT_W - 1);
        o_st.out_free   = !r_out_valid || o_out.ready;
    end

    // checks
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && frame_end) |=> (r_t == '0 && r_pidx == '0))
        else $error("frame counters not cleared after last result");

    a_emit_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_pidx < r_total))
        else $error("result position beyond frame");

    a_sqrt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sqrt_step |-> (r_bit != '0))
        else $error("square root stepped past its last bit pair");

endmodule

// ===== hdl/local_window_stddev_filter_top.sv =====
// local_window_stddev_filter_top: local standard deviation over a square window
// depends on lwsd_pkg, lwsd_if, lwsd_ctrl, lwsd_datapath
//
//  channel  dir  fields                      beat
//  i_in     in   pixel[7:0], drain           one raster pixel or padding item
//  o_out    out  deviation[7:0], frame_last  one result, raster order
//  i_cfg    in   index[2:0], data[12:0]      one register write
//
// one beat at a time: a beat without result skips the scan, a border result is
// emitted as zero, a masked centre or an empty window ends after the scan, and
// an interior result goes on to square root and divide; the scan is set by the
// single read port of the row store, which it walks one pixel a cycle
// reset is synchronous, active low; the row store needs no clearing
// a full output register holds the next result back until o_out is taken
module local_window_stddev_filter_top import lwsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lwsd_in_if.sink     i_in,
    lwsd_out_if.source  o_out,
    lwsd_cfg_if.sink    i_cfg
);

    t_cmd    cmd;
    t_status st;

    // sequencer
    lwsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    // storage and arithmetic
    lwsd_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_st    (st),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule

// ===== dv/local_window_stddev_filter_top_tb.sv =====
// local_window_stddev_filter_top_tb: self-checking bench for the local window
// standard deviation filter, with random frames, stalls and register changes
// depends on lwsd_pkg, lwsd_if and local_window_stddev_filter_top
`timescale 1ns / 100ps

module local_window_stddev_filter_top_tb;
    import lwsd_pkg::*;

    // settling time that covers one interior result at the largest window
    localparam int SETTLE_CYCLES = 1500;

    typedef struct {
        logic [PIX_W-1:0] deviation;
        logic             frame_last;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    lwsd_in_if  in_ch();
    lwsd_out_if out_ch();
    lwsd_cfg_if cfg_ch();

    local_window_stddev_filter_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    // predictor copy of the registers and frame position
    logic [DIM_W-1:0]  cur_width;
    logic [DIM_W-1:0]  cur_height;
    logic [HALF_W-1:0] cur_half;
    logic              cur_nonzero;
    logic              cur_mask;
    int unsigned       frame_pos;
    logic [PIX_W-1:0]  frame_pix [int];

    t_result pending_results[$];
    int      error_count = 0;
    int      items_sent  = 0;
    bit      in_idle_on  = 1;
    bit      out_idle_on = 1;
    int      long_hold   = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned eff_width();
        if (cur_width == 0) return 1;
        if (cur_width > MAX_WIDTH) return MAX_WIDTH;
        return cur_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cur_height == 0) return 1;
        if (cur_height > MAX_HEIGHT) return MAX_HEIGHT;
        return cur_height;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    // deviation of the window centred on frame position p
    function automatic logic [PIX_W-1:0] window_deviation(int unsigned p);
        int unsigned     w, h, m, r, c;
        longint unsigned sum_a, sum_b, nz, n, v, d, px;
        w = eff_width();
        h = eff_height();
        m = cur_half;
        r = p / w;
        c = p % w;
        sum_a = 0;
        sum_b = 0;
        nz = 0;
        if (r < m || c < m || r + m >= h || c + m >= w) return '0;
        if (cur_mask && frame_pix[p] == 0) return '0;
        for (int unsigned i = r - m; i <= r + m; i++) begin
            for (int unsigned j = c - m; j <= c + m; j++) begin
                px = frame_pix[i * w + j];
                sum_b += px;
                sum_a += px * px;
                if (px != 0) nz++;
            end
        end
        n = cur_nonzero ? nz : longint'((2 * m + 1) * (2 * m + 1));
        if (n == 0) return '0;
        v = n * sum_a;
        if (v < sum_b * sum_b) return '0;
        v -= sum_b * sum_b;
        d = root_floor(v) / n;
        return (d > 255) ? 8'd255 : d[7:0];
    endfunction

    // advance the predictor by one accepted beat
    task automatic predict_beat(input logic [PIX_W-1:0] pix, input logic drn);
        int unsigned w, total, delay, t, p;
        t_result     res;
        w = eff_width();
        total = w * eff_height();
        delay = cur_half * w + cur_half;
        t = frame_pos;
        if (t < total) begin
            if (drn) return;
            frame_pix[t] = pix;
        end
        frame_pos = t + 1;
        if (t < delay) return;
        p = t - delay;
        res.deviation = window_deviation(p);
        res.frame_last = (p == total - 1);
        pending_results.push_back(res);
        if (p >= total - 1) frame_pos = 0;
    endtask

    // result checker
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result dev=%0d last=%0b", $time,
                         out_ch.deviation, out_ch.frame_last);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (want.deviation !== out_ch.deviation) begin
                    $display("%0t: deviation expected %0d actual %0d", $time,
                             want.deviation, out_ch.deviation);
                    error_count++;
                end
                if (want.frame_last !== out_ch.frame_last) begin
                    $display("%0t: frame_last expected %0b actual %0b", $time,
                             want.frame_last, out_ch.frame_last);
                    error_count++;
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        int stall_left;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else if (long_hold > 0) begin
            out_ch.ready <= 1'b0;
            long_hold--;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 12);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // one pixel beat; valid stays high for a following beat
    task automatic send_beat(input logic [PIX_W-1:0] pix, input logic drn);
        bit ok;
        if (in_idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.pixel <= pix;
        in_ch.drain <= drn;
        do begin
            @(negedge i_clk);
            ok = in_ch.ready;
            @(posedge i_clk);
        end while (!ok);
        predict_beat(pix, drn);
    endtask

    // drop valid and wait until the block has nothing left in flight
    task automatic settle();
        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        bit ok;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do begin
            @(negedge i_clk);
            ok = cfg_ch.ready;
            @(posedge i_clk);
        end while (!ok);
        case (idx)
            REG_IMAGE_WIDTH:   cur_width   = value;
            REG_IMAGE_HEIGHT:  cur_height  = value;
            REG_HALF_WINDOW:   cur_half    = value[HALF_W-1:0];
            REG_COUNT_NONZERO: cur_nonzero = value[0];
            REG_MASK_ZERO:     cur_mask    = value[0];
            default: return;
        endcase
        frame_pos = 0;
    endtask

    // full register set; unused upper data bits carry random junk
    task automatic apply_config(input int w, input int h, input int m,
                                input bit nz, input bit mask);
        settle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_HALF_WINDOW, {9'($urandom), 4'(m)});
        write_reg(REG_COUNT_NONZERO, {12'($urandom), nz});
        write_reg(REG_MASK_ZERO, {12'($urandom), mask});
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel(input int zero_pct);
        if ($urandom_range(0, 99) < zero_pct) return '0;
        if ($urandom_range(0, 9) == 0) return 8'd255;
        return 8'($urandom);
    endfunction

    // one frame of pixels and padding; noise adds ignored and dropped beats,
    // pause_at waits for every result at that pixel, cut stops the frame early
    task automatic run_frame(input int w, input int h, input int m, input bit nz,
                             input bit mask, input bit noise, input int pause_at,
                             input int cut);
        int n_pix, n_pad;
        apply_config(w, h, m, nz, mask);
        n_pix = w * h;
        n_pad = m * w + m;
        for (int k = 0; k < n_pix; k++) begin
            if (k == cut) return;
            if (k == pause_at) begin
                in_ch.valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge i_clk);
            end
            if (noise && $urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b1);
            send_beat(rand_pixel(25), 1'b0);
            items_sent++;
        end
        for (int k = 0; k < n_pad; k++) begin
            send_beat(8'($urandom), !(noise && $urandom_range(0, 7) == 0));
            items_sent++;
        end
    endtask

    task automatic test_directed();
        logic [PIX_W-1:0] pix [0:8];
        pix = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd0, 8'd77};
        // 3x3 frame, one interior pixel, with a drain beat among the pixels
        apply_config(3, 3, 1, 1'b1, 1'b0);
        for (int k = 0; k < 9; k++) begin
            if (k == 4) send_beat(8'hA5, 1'b1);
            send_beat(pix[k], 1'b0);
        end
        send_beat(8'd200, 1'b0);
        send_beat(8'd0, 1'b1);
        send_beat(8'd0, 1'b1);
        send_beat(8'd0, 1'b1);
        // all-zero window in nonzero mode, then full-area divisor
        apply_config(3, 3, 1, 1'b1, 1'b0);
        repeat (13) send_beat(8'd0, 1'b0);
        apply_config(3, 3, 1, 1'b0, 1'b1);
        for (int k = 0; k < 13; k++) send_beat(k == 4 ? 8'd0 : 8'd255, k >= 9);
        // unknown register index leaves the frame running
        apply_config(1, 1, 0, 1'b1, 1'b1);
        write_reg(CFG_IDX_W'(7), 13'h1FFF);
        cfg_ch.valid <= 1'b0;
        send_beat(8'd0, 1'b0);
        send_beat(8'd9, 1'b0);
        // zero and oversized dimensions
        apply_config(0, 0, 0, 1'b0, 1'b0);
        send_beat(8'd33, 1'b0);
        apply_config(8191, 1, 0, 1'b1, 1'b0);
        repeat (3) send_beat(8'($urandom), 1'b0);
        apply_config(1, 8191, 0, 1'b0, 1'b0);
        repeat (3) send_beat(8'($urandom), 1'b0);
    endtask

    task automatic test_largest_window();
        in_idle_on = 0;
        run_frame(17, 17, 8, 1'b0, 1'b0, 1'b0, -1, -1);
        in_idle_on = 1;
    endtask

    // receiver holds off while the sender keeps offering, then a pause
    // that waits for every result
    task automatic test_backpressure();
        apply_config(6, 5, 1, 1'b1, 1'b0);
        long_hold = 700;
        in_idle_on = 0;
        for (int k = 0; k < 30; k++) begin
            if (k == 20) begin
                in_ch.valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge i_clk);
            end
            send_beat(rand_pixel(25), 1'b0);
            items_sent++;
        end
        for (int k = 0; k < 7; k++) begin
            send_beat(8'($urandom), 1'b1);
            items_sent++;
        end
        in_idle_on = 1;
    endtask

    task automatic test_random_frames();
        int w, h, m;
        while (items_sent < 950) begin
            if (items_sent > 800) begin
                in_idle_on = 0;
                out_idle_on = 0;
            end
            m = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
            w = $urandom_range(1, 2 * m + 8);
            h = $urandom_range(1, 2 * m + 6);
            run_frame(w, h, m, $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(0, 3) == 0, -1,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, w * h) : -1);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.pixel  = '0;
        in_ch.drain  = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
        cur_width    = RST_IMAGE_WIDTH;
        cur_height   = RST_IMAGE_HEIGHT;
        cur_half     = RST_HALF_WINDOW;
        cur_nonzero  = RST_COUNT_NONZERO;
        cur_mask     = RST_MASK_ZERO;
        frame_pos    = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_largest_window();
        test_backpressure();
        test_random_frames();

        settle();
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
